// ===== hdl/lprp_pkg.sv =====
package lprp_pkg;

    // Fixed field widths of the byte channel and the tag channel.
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 4;
    localparam int INDEX_W  = 32;
    localparam int LEN_W    = 32;
    localparam int STATUS_W = 2;

    // A length or count header is four big-endian bytes.
    localparam int HDR_BYTES = 4;
    localparam int HDR_CNT_W = $clog2(HDR_BYTES);

    // Field kind tags reported with every byte.
    typedef enum logic [KIND_W-1:0] {
        KIND_ID_LEN   = 4'd0,
        KIND_ID       = 4'd1,
        KIND_METHOD   = 4'd2,
        KIND_ARG1_LEN = 4'd3,
        KIND_ARG1     = 4'd4,
        KIND_ARG2_LEN = 4'd5,
        KIND_ARG2     = 4'd6,
        KIND_COUNT    = 4'd7,
        KIND_PREREQ   = 4'd8
    } kind_t;

    // Record status reported with the last byte.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_PENDING   = 2'd0,
        STATUS_OK        = 2'd1,
        STATUS_TRUNCATED = 2'd2,
        STATUS_TRAILING  = 2'd3
    } status_t;

    // Sticky error code of the record being parsed.
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_TRAILING = 2'd3
    } err_t;

    // One tagged byte as it leaves the parser.
    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        kind_t              field_kind;
        logic               is_payload;
        logic               field_last;
        logic [INDEX_W-1:0] prereq_index;
        logic               record_done;
        status_t            status;
    } result_t;

endpackage

// ===== hdl/lprp_ifs.sv =====
// Byte channel into the parser.
interface lprp_in_if
    import lprp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              record_end;

    modport source (output valid, output data_byte, output record_end, input ready);
    modport sink   (input valid, input data_byte, input record_end, output ready);
endinterface

// Tagged byte channel out of the parser.
interface lprp_out_if
    import lprp_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_byte;
    logic [KIND_W-1:0]   field_kind;
    logic                is_payload;
    logic                field_last;
    logic [INDEX_W-1:0]  prereq_index;
    logic                record_done;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output out_byte, output field_kind, output is_payload,
                    output field_last, output prereq_index, output record_done,
                    output status, input ready);
    modport sink   (input valid, input out_byte, input field_kind, input is_payload,
                    input field_last, input prereq_index, input record_done,
                    input status, output ready);
endinterface

// ===== hdl/lprp_parser.sv =====
module lprp_parser
    import lprp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              record_end,
    output result_t           result
);

    typedef enum logic [11:0] {
        PH_ID_LEN   = 12'b0000_0000_0001,
        PH_ID       = 12'b0000_0000_0010,
        PH_METHOD   = 12'b0000_0000_0100,
        PH_ARG1_LEN = 12'b0000_0000_1000,
        PH_ARG1     = 12'b0000_0001_0000,
        PH_ARG2_LEN = 12'b0000_0010_0000,
        PH_ARG2     = 12'b0000_0100_0000,
        PH_COUNT    = 12'b0000_1000_0000,
        PH_PRE_LEN  = 12'b0001_0000_0000,
        PH_PRE_DATA = 12'b0010_0000_0000,
        PH_AFTER    = 12'b0100_0000_0000,
        PH_ERROR    = 12'b1000_0000_0000
    } phase_t;

    localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HDR_BYTES - 1);

    phase_t               phase_reg, phase_next;
    logic [HDR_CNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [LEN_W-1:0]     len_shift_reg, len_shift_next;
    logic [LEN_W-1:0]     bytes_left_reg, bytes_left_next;
    logic [LEN_W-1:0]     pre_left_reg, pre_left_next;
    logic [INDEX_W-1:0]   pre_cnt_reg, pre_cnt_next;
    err_t                 err_reg, err_next;

    logic [LEN_W-1:0]     hdr_value;
    logic                 hdr_done;
    logic                 hdr_phase;
    logic [LEN_W-1:0]     bytes_dec;
    logic [LEN_W-1:0]     pre_left_dec;

    // Header assembly and the two down counters.
    assign hdr_value    = {len_shift_reg[LEN_W-BYTE_W-1:0], data_byte};
    assign hdr_done     = (hdr_cnt_reg == HDR_LAST);
    assign bytes_dec    = bytes_left_reg - LEN_W'(bytes_left_reg != '0);
    assign pre_left_dec = pre_left_reg - LEN_W'(pre_left_reg != '0);

    // Tag the byte and work out the next parse state.
    always_comb
    begin
        phase_next      = phase_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        len_shift_next  = len_shift_reg;
        bytes_left_next = bytes_left_reg;
        pre_left_next   = pre_left_reg;
        pre_cnt_next    = pre_cnt_reg;
        err_next        = err_reg;
        hdr_phase       = 1'b0;

        result              = '0;
        result.out_byte     = data_byte;
        result.field_kind   = KIND_ID_LEN;
        result.record_done  = record_end;
        result.status       = STATUS_PENDING;

        unique case (phase_reg)
            PH_ID_LEN:
            begin
                hdr_phase = 1'b1;
                result.field_kind = KIND_ID_LEN;
                if (hdr_done)
                begin
                    bytes_left_next = hdr_value;
                    phase_next = (hdr_value == '0) ? PH_METHOD : PH_ID;
                end
            end
            PH_ARG1_LEN:
            begin
                hdr_phase = 1'b1;
                result.field_kind = KIND_ARG1_LEN;
                if (hdr_done)
                begin
                    bytes_left_next = hdr_value;
                    phase_next = (hdr_value == '0) ? PH_ARG2_LEN : PH_ARG1;
                end
            end
            PH_ARG2_LEN:
            begin
                hdr_phase = 1'b1;
                result.field_kind = KIND_ARG2_LEN;
                if (hdr_done)
                begin
                    bytes_left_next = hdr_value;
                    phase_next = (hdr_value == '0) ? PH_COUNT : PH_ARG2;
                end
            end
            PH_COUNT:
            begin
                hdr_phase = 1'b1;
                result.field_kind = KIND_COUNT;
                if (hdr_done)
                begin
                    pre_left_next = hdr_value;
                    phase_next = (hdr_value == '0) ? PH_AFTER : PH_PRE_LEN;
                end
            end
            PH_PRE_LEN:
            begin
                hdr_phase = 1'b1;
                result.field_kind   = KIND_PREREQ;
                result.prereq_index = pre_cnt_reg;
                if (hdr_done)
                begin
                    if (hdr_value == '0)
                    begin
                        // An empty prerequisite finishes at once.
                        pre_cnt_next  = pre_cnt_reg + INDEX_W'(1);
                        pre_left_next = pre_left_dec;
                        phase_next = (pre_left_dec == '0) ? PH_AFTER : PH_PRE_LEN;
                    end
                    else
                    begin
                        bytes_left_next = hdr_value;
                        phase_next = PH_PRE_DATA;
                    end
                end
            end
            PH_ID, PH_ARG1, PH_ARG2, PH_PRE_DATA:
            begin
                result.is_payload = 1'b1;
                bytes_left_next   = bytes_dec;
                result.field_last = (bytes_dec == '0);
                unique case (phase_reg)
                    PH_ID:       result.field_kind = KIND_ID;
                    PH_ARG1:     result.field_kind = KIND_ARG1;
                    PH_ARG2:     result.field_kind = KIND_ARG2;
                    default:     result.field_kind = KIND_PREREQ;
                endcase
                if (phase_reg == PH_PRE_DATA)
                begin
                    result.prereq_index = pre_cnt_reg;
                end
                if (bytes_dec == '0)
                begin
                    unique case (phase_reg)
                        PH_ID:   phase_next = PH_METHOD;
                        PH_ARG1: phase_next = PH_ARG2_LEN;
                        PH_ARG2: phase_next = PH_COUNT;
                        default:
                        begin
                            pre_cnt_next  = pre_cnt_reg + INDEX_W'(1);
                            pre_left_next = pre_left_dec;
                            phase_next = (pre_left_dec == '0) ? PH_AFTER : PH_PRE_LEN;
                        end
                    endcase
                end
            end
            PH_METHOD:
            begin
                result.field_kind = KIND_METHOD;
                result.is_payload = 1'b1;
                result.field_last = 1'b1;
                phase_next = PH_ARG1_LEN;
            end
            PH_AFTER:
            begin
                err_next   = ERR_TRAILING;
                phase_next = PH_ERROR;
            end
            default:
            begin
                // Error phase: bytes up to the record end are only flagged.
                if (err_reg == ERR_NONE)
                begin
                    err_next = ERR_TRAILING;
                end
                phase_next = PH_ERROR;
            end
        endcase

        // Header bytes shift into the length register, four to a value.
        if (hdr_phase)
        begin
            hdr_cnt_next   = hdr_done ? '0 : hdr_cnt_reg + HDR_CNT_W'(1);
            len_shift_next = hdr_done ? '0 : hdr_value;
        end

        // Record end: report the status and return to the start state.
        if (record_end)
        begin
            if (err_next != ERR_NONE)
            begin
                result.status = STATUS_TRAILING;
            end
            else if (phase_next == PH_AFTER || (phase_next == PH_COUNT && hdr_cnt_next == '0))
            begin
                result.status = STATUS_OK;
            end
            else
            begin
                result.status = STATUS_TRUNCATED;
            end
            phase_next      = PH_ID_LEN;
            hdr_cnt_next    = '0;
            len_shift_next  = '0;
            bytes_left_next = '0;
            pre_left_next   = '0;
            pre_cnt_next    = '0;
            err_next        = ERR_NONE;
        end
    end

    // Parse state advances once per request that moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_ID_LEN;
            hdr_cnt_reg    <= '0;
            len_shift_reg  <= '0;
            bytes_left_reg <= '0;
            pre_left_reg   <= '0;
            pre_cnt_reg    <= '0;
            err_reg        <= ERR_NONE;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            len_shift_reg  <= len_shift_next;
            bytes_left_reg <= bytes_left_next;
            pre_left_reg   <= pre_left_next;
            pre_cnt_reg    <= pre_cnt_next;
            err_reg        <= err_next;
        end
    end

    // A record end always brings the parser back to the start state.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && record_end |=> phase_reg == PH_ID_LEN && hdr_cnt_reg == '0 && err_reg == ERR_NONE)
        else $error("parser did not return to start after record end");

    // A partly assembled header only exists in a header phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        hdr_cnt_reg != '0 |-> phase_reg == PH_ID_LEN || phase_reg == PH_ARG1_LEN ||
            phase_reg == PH_ARG2_LEN || phase_reg == PH_COUNT || phase_reg == PH_PRE_LEN)
        else $error("header byte count outside a header phase");

    // The error code is set exactly while the parser sits in the error phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ERR_NONE) == (phase_reg == PH_ERROR))
        else $error("error code and error phase disagree");

    // Payload phases always have bytes left to count down.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ID || phase_reg == PH_ARG1 || phase_reg == PH_ARG2 ||
            phase_reg == PH_PRE_DATA |-> bytes_left_reg != '0)
        else $error("payload phase with no bytes left");

endmodule

// ===== hdl/length_prefixed_record_parser_unit.sv =====
// Length-prefixed record parser.
// byte_stream takes one record byte per request, with record_end set on the
// record's last byte. tag_stream returns every byte once, in order, tagged
// with its field kind, payload flag, field-last flag and prerequisite index;
// the request that carries record_end also carries the record status.
// Both channels are valid/ready; a request moves when both are high.
// A byte accepted on byte_stream passes through the input register, then the
// result register, before it is presented on tag_stream.
// Throughput: one byte per cycle sustained while tag_stream is ready; the parse
// state and its 32-bit counters update once per byte.
// When tag_stream stalls, the result register holds and the input register
// still takes one more byte; byte_stream drops ready only while both are full.
// Reset empties both registers and puts the parser at the start of a record,
// expecting the id length.
module length_prefixed_record_parser_unit
    import lprp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lprp_in_if.sink    byte_stream,
    lprp_out_if.source tag_stream
);

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_end_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_res_reg;
    result_t           parsed;
    logic              out_load;
    logic              advance;
    logic              accept;

    // Pipeline flow control.
    assign out_load          = !out_valid_reg || tag_stream.ready;
    assign advance           = in_valid_reg && out_load;
    assign byte_stream.ready = !in_valid_reg || out_load;
    assign accept            = byte_stream.valid && byte_stream.ready;

    assign in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = out_load ? in_valid_reg : out_valid_reg;

    lprp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .data_byte  (in_byte_reg),
        .record_end (in_end_reg),
        .result     (parsed)
    );

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= byte_stream.data_byte;
            in_end_reg  <= byte_stream.record_end;
        end
        if (advance)
        begin
            out_res_reg <= parsed;
        end
    end

    // Output channel.
    assign tag_stream.valid        = out_valid_reg;
    assign tag_stream.out_byte     = out_res_reg.out_byte;
    assign tag_stream.field_kind   = out_res_reg.field_kind;
    assign tag_stream.is_payload   = out_res_reg.is_payload;
    assign tag_stream.field_last   = out_res_reg.field_last;
    assign tag_stream.prereq_index = out_res_reg.prereq_index;
    assign tag_stream.record_done  = out_res_reg.record_done;
    assign tag_stream.status       = out_res_reg.status;

    // A held input byte is not dropped while the result register is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !tag_stream.ready |=> in_valid_reg)
        else $error("input byte lost during output stall");

    // A byte that moves on always lands in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced byte missing from result register");

    // A status is only reported on the byte that ends a record.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_res_reg.record_done |-> out_res_reg.status == STATUS_PENDING)
        else $error("status reported before record end");

endmodule
